### src/kdq_pkg.sv
// kdq_pkg: shared types and constants of the keypad debounce and repeat queue
// used by the interfaces, the key lanes, the merge stage, the queue and the top level
package kdq_pkg;

	// fixed field widths
	localparam int RAW_W     = 7;
	localparam int EVT_W     = 3;
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// request codes
	localparam logic REQ_POLL = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_INIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_FAST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REP_NORMAL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REP_FAST    = 3'd4;

	// register reset values
	localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 16'd20;
	localparam logic [CFG_W-1:0] RST_HOLD_INIT  = 16'd500;
	localparam logic [CFG_W-1:0] RST_HOLD_FAST  = 16'd1500;
	localparam logic [CFG_W-1:0] RST_REP_NORMAL = 16'd150;
	localparam logic [CFG_W-1:0] RST_REP_FAST   = 16'd50;

	typedef struct packed {
		logic [CFG_W-1:0] debounce;
		logic [CFG_W-1:0] hold_init;
		logic [CFG_W-1:0] hold_fast;
		logic [CFG_W-1:0] rep_normal;
		logic [CFG_W-1:0] rep_fast;
	} cfg_regs_t;

	// lane sequencing strobes
	typedef struct packed {
		logic eval;
		logic upd;
	} lane_ctl_t;

	// one event write into the queue
	typedef struct packed {
		logic             valid;
		logic [EVT_W-1:0] code;
	} push_t;

endpackage

### src/kdq_ifs.sv
// kdq_ifs: valid/ready channel interfaces for requests, results and register writes
// depends on kdq_pkg for the field widths
interface kdq_req_if;
	import kdq_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [RAW_W-1:0]  raw_pressed;
	logic [TIME_W-1:0] now_ms;
	modport source (output valid, req_type, raw_pressed, now_ms, input ready);
	modport sink (input valid, req_type, raw_pressed, now_ms, output ready);
endinterface

interface kdq_rsp_if #(parameter int COUNT_W = 5);
	import kdq_pkg::*;
	logic               valid;
	logic               ready;
	logic [EVT_W-1:0]   popped_event;
	logic [EVT_W-1:0]   head_event;
	logic [COUNT_W-1:0] queue_count;
	logic               has_event;
	modport source (output valid, popped_event, head_event, queue_count, has_event,
		input ready);
	modport sink (input valid, popped_event, head_event, queue_count, has_event,
		output ready);
endinterface

interface kdq_cfg_if;
	import kdq_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/keypad_debounce_autorepeat_queue.sv
// Keypad controller: per-key debounce, typematic auto-repeat and a drop-oldest event
// queue. One lane per key evaluates a poll in an eval step and an update step, all lanes
// side by side; the merge stage then writes the found events into the queue one per cycle
// in key order, since the queue memory has one write port. A poll passes the states EVAL,
// UPD, PUSH (until the merge stage is done), HEAD and DONE; a pop passes HEAD and DONE.
// The result sits in an output register, so the next item may be accepted while it
// waits; registers may be written only while the block is idle.
// depends on kdq_pkg, kdq_ifs, kdq_lane, kdq_merge, kdq_queue
module keypad_debounce_autorepeat_queue
	import kdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int KEY_COUNT   = 7
) (
	input logic      clk,
	input logic      arst_n,
	kdq_req_if.sink  req,
	kdq_rsp_if.source rsp,
	kdq_cfg_if.sink  cfg
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_PUSH = 3'd3;
	localparam logic [2:0] ST_HEAD = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]          state_q;
	cfg_regs_t           cfg_q;
	logic [RAW_W-1:0]    raw_q;
	logic [TIME_W-1:0]   now_q;
	logic [EVT_W-1:0]    popped_q;

	logic                rsp_valid_q;
	logic [EVT_W-1:0]    rsp_popped_q;
	logic [EVT_W-1:0]    rsp_head_q;
	logic [CNT_W-1:0]    rsp_count_q;
	logic                rsp_has_q;

	logic                accept;
	logic                pop;
	logic                out_free;
	lane_ctl_t           lane_ctl;
	logic [KEY_COUNT-1:0] found;
	push_t               push;
	logic                busy;
	logic [EVT_W-1:0]    head_code;
	logic [CNT_W-1:0]    count;

	assign req.ready = state_q == ST_IDLE;
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;
	assign pop       = accept && (req.req_type == REQ_POP);
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign lane_ctl.eval = state_q == ST_EVAL;
	assign lane_ctl.upd  = state_q == ST_UPD;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce   <= RST_DEBOUNCE;
			cfg_q.hold_init  <= RST_HOLD_INIT;
			cfg_q.hold_fast  <= RST_HOLD_FAST;
			cfg_q.rep_normal <= RST_REP_NORMAL;
			cfg_q.rep_fast   <= RST_REP_FAST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_DEBOUNCE:   cfg_q.debounce   <= cfg.data;
				REG_HOLD_INIT:  cfg_q.hold_init  <= cfg.data;
				REG_HOLD_FAST:  cfg_q.hold_fast  <= cfg.data;
				REG_REP_NORMAL: cfg_q.rep_normal <= cfg.data;
				REG_REP_FAST:   cfg_q.rep_fast   <= cfg.data;
				default: ;
			endcase
		end
	end

	// one lane per key, keys past the raw field read as released
	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
		logic level;
		if (k < RAW_W) begin : g_wired
			assign level = raw_q[k];
		end else begin : g_absent
			assign level = 1'b0;
		end
		kdq_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.level  (level),
			.now    (now_q),
			.cfg    (cfg_q),
			.emit   (found[k])
		);
	end

	// merge the lane results in key order
	kdq_merge #(
		.KEY_COUNT (KEY_COUNT)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (lane_ctl.upd),
		.found  (found),
		.push   (push),
		.busy   (busy)
	);

	kdq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head_code (head_code),
		.count_q   (count)
	);

	// item latch
	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q    <= req.raw_pressed;
			now_q    <= req.now_ms;
			popped_q <= (pop && count != '0) ? head_code : '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= pop ? ST_HEAD : ST_EVAL;
					end
				end
				ST_EVAL: state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_PUSH;
				ST_PUSH: begin
					if (!busy) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_popped_q <= popped_q;
			rsp_head_q   <= (count != '0) ? head_code : '0;
			rsp_count_q  <= count;
			rsp_has_q    <= count != '0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_event = rsp_popped_q;
	assign rsp.head_event   = rsp_head_q;
	assign rsp.queue_count  = rsp_count_q;
	assign rsp.has_event    = rsp_has_q;

	// queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// a pop of a nonempty queue removes exactly one entry
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && count != '0) |=> count == $past(count) - 1'b1)
		else $error("pop did not remove one entry");

	// queue writes happen only while events are being merged
	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> state_q == ST_PUSH)
		else $error("queue write outside merge phase");

	// no item is taken while a poll is still in the lanes
	a_lane_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_ctl.eval || lane_ctl.upd) |-> !req.ready)
		else $error("request ready during lane evaluation");

endmodule

### src/kdq_ram.sv
// kdq_ram: generic single-write, single-read memory with registered read data
// no dependencies
module kdq_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

### src/kdq_lane.sv
// kdq_lane: debounce and auto-repeat timing for one key
// depends on kdq_pkg; two steps per poll: time differences, then decision
module kdq_lane
	import kdq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lane_ctl_t         ctl,
	input  logic              level,
	input  logic [TIME_W-1:0] now,
	input  cfg_regs_t         cfg,
	output logic              emit
);

	logic              last_raw_q;
	logic              stable_q;
	logic [TIME_W-1:0] change_q;
	logic [TIME_W-1:0] press_q;
	logic [TIME_W-1:0] repeat_q;

	logic              lvl_s1;
	logic              settled_s1;
	logic              fast_s1;
	logic              init_s1;
	logic [TIME_W-1:0] rep_s1;

	logic              changed;
	logic [TIME_W-1:0] dchg;
	logic [TIME_W-1:0] held;
	logic [CFG_W-1:0]  gap;
	logic              rep_ok;

	// first step: elapsed times since change, press and last repeat
	assign changed = level != last_raw_q;
	assign dchg    = changed ? '0 : now - change_q;
	assign held    = now - press_q;

	// second step: pick repeat spacing and decide
	assign gap    = fast_s1 ? cfg.rep_fast : cfg.rep_normal;
	assign rep_ok = rep_s1 >= {{(TIME_W-CFG_W){1'b0}}, gap};
	assign emit   = ctl.upd && settled_s1 && lvl_s1
		&& (!stable_q || ((fast_s1 || init_s1) && rep_ok));

	// timing flags of the current poll
	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			lvl_s1     <= level;
			settled_s1 <= dchg >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce};
			fast_s1    <= held >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_fast};
			init_s1    <= held >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_init};
			rep_s1     <= now - repeat_q;
		end
	end

	// key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b0;
			stable_q   <= 1'b0;
			change_q   <= '0;
			press_q    <= '0;
			repeat_q   <= '0;
		end else begin
			if (ctl.eval && changed) begin
				last_raw_q <= level;
				change_q   <= now;
			end
			// press, release and repeat exclude each other; a steady key may match none
			if (ctl.upd && settled_s1) begin
				if (lvl_s1 && !stable_q) begin
					stable_q <= 1'b1;
					press_q  <= now;
					repeat_q <= now;
				end else if (!lvl_s1 && stable_q) begin
					stable_q <= 1'b0;
				end else if (emit) begin
					repeat_q <= now;
				end
			end
		end
	end

endmodule

### src/kdq_merge.sv
// kdq_merge: collects the events found by the lanes and hands them out in key order
// depends on kdq_pkg; one event per cycle
module kdq_merge
	import kdq_pkg::*;
#(
	parameter int KEY_COUNT = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [KEY_COUNT-1:0] found,
	output push_t                push,
	output logic                 busy
);

	logic [KEY_COUNT-1:0] pending_q;
	logic [KEY_COUNT-1:0] lowest;
	logic [EVT_W-1:0]     code;

	// isolate the lowest pending key and form its event code
	assign lowest = pending_q & (~pending_q + 1'b1);
	always_comb begin
		code = '0;
		for (int i = 0; i < KEY_COUNT; i++) begin
			if (lowest[i]) begin
				code = code | EVT_W'(i + 1);
			end
		end
	end

	assign busy       = |pending_q;
	assign push.valid = busy;
	assign push.code  = code;

	// pending keys of the current poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (load) begin
			pending_q <= found;
		end else begin
			pending_q <= pending_q & ~lowest;
		end
	end

endmodule

### src/kdq_queue.sv
// kdq_queue: circular event queue that drops its oldest entry when full
// depends on kdq_pkg and kdq_ram
module kdq_queue
	import kdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  push_t                      push,
	input  logic                       pop,
	output logic [EVT_W-1:0]           head_code,
	output logic [$clog2(DEPTH+1)-1:0] count_q
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL = CNT_W'(DEPTH);

	logic [ADDR_W-1:0] head_q;
	logic [ADDR_W-1:0] tail_q;
	logic [ADDR_W-1:0] head_nxt;
	logic [ADDR_W-1:0] tail_nxt;
	logic              full;
	logic              nonempty;

	assign head_nxt = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign full     = count_q == FULL;
	assign nonempty = count_q != '0;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (push.valid) begin
			tail_q <= tail_nxt;
			if (full) begin
				head_q <= head_nxt;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end else if (pop && nonempty) begin
			head_q  <= head_nxt;
			count_q <= count_q - 1'b1;
		end
	end

	// event storage, read port follows the head
	kdq_ram #(
		.WIDTH (EVT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (push.valid),
		.waddr   (tail_q),
		.wdata   (push.code),
		.raddr   (head_q),
		.rdata_q (head_code)
	);

endmodule
